FILE: hdl/cpsc_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and field layout for the CPU power-state coordinator.
package cpsc_pkg;

    // Field widths
    localparam int CMD_W     = 4;
    localparam int AFF_W     = 40;
    localparam int CIDX_W    = 8;
    localparam int ENTRY_W   = 64;
    localparam int CTX_W     = 64;
    localparam int FN_W      = 32;
    localparam int STATUS_W  = 3;
    localparam int VALUE_W   = 31;
    localparam int MAJOR_W   = 15;
    localparam int MINOR_W   = 16;

    // Input word layout, lowest bit first
    localparam int AFF_LSB   = 0;
    localparam int CIDX_LSB  = AFF_LSB + AFF_W;
    localparam int ENTRY_LSB = CIDX_LSB + CIDX_W;
    localparam int CTX_LSB   = ENTRY_LSB + ENTRY_W;
    localparam int FN_LSB    = CTX_LSB + CTX_W;
    localparam int IN_BITS   = FN_LSB + FN_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

    // Output word layout
    localparam int STATUS_LSB = 0;
    localparam int VALUE_LSB  = STATUS_LSB + STATUS_W;
    localparam int OUT_BITS   = VALUE_LSB + VALUE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MAJOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION_MINOR = 1'b1;
    localparam logic [MAJOR_W-1:0]   MAJOR_RESET = 15'd1;
    localparam logic [MINOR_W-1:0]   MINOR_RESET = 16'd2;

    // Commands
    localparam logic [CMD_W-1:0] CMD_REGISTER     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_VERSION      = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CPU_ON       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_CPU_OFF      = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SUSPEND      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_AFFINITY     = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SYSTEM_RESET = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FEATURES     = 4'd8;

    // Result status
    typedef enum logic [STATUS_W-1:0] {
        ST_SUCCESS         = 3'd0,
        ST_NOT_SUPPORTED   = 3'd1,
        ST_INVALID_PARAMS  = 3'd2,
        ST_DENIED          = 3'd3,
        ST_ALREADY_ON      = 3'd4,
        ST_PENDING         = 3'd5,
        ST_INVALID_ADDRESS = 3'd6,
        ST_TABLE_FULL      = 3'd7
    } t_status;

    // Affinity state as reported
    localparam logic [VALUE_W-1:0] PW_ON  = 31'd0;
    localparam logic [VALUE_W-1:0] PW_OFF = 31'd1;

    // SMC32 function identifiers
    localparam logic [FN_W-1:0] FN_VERSION        = 32'h8400_0000;
    localparam logic [FN_W-1:0] FN_CPU_SUSPEND    = 32'h8400_0001;
    localparam logic [FN_W-1:0] FN_CPU_OFF        = 32'h8400_0002;
    localparam logic [FN_W-1:0] FN_CPU_ON         = 32'h8400_0003;
    localparam logic [FN_W-1:0] FN_AFFINITY_INFO  = 32'h8400_0004;
    localparam logic [FN_W-1:0] FN_SHUTDOWN       = 32'h8400_0008;
    localparam logic [FN_W-1:0] FN_SYSTEM_RESET   = 32'h8400_0009;
    localparam logic [FN_W-1:0] FN_FEATURES       = 32'h8400_000A;
    localparam logic [FN_W-1:0] FN_STAT_RESIDENCY = 32'h8400_0010;
    localparam logic [FN_W-1:0] FN_STAT_COUNT     = 32'h8400_0011;
    localparam logic [FN_W-1:0] FN_SYSTEM_RESET2  = 32'h8400_0012;
    localparam logic [FN_W-1:0] FN_MEM_PROTECT    = 32'h8400_0013;

endpackage

FILE: hdl/cpsc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module cpsc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

FILE: hdl/cpu_power_state_coordinator_unit.sv
`timescale 1ns / 1ps
// CPU power-state coordinator: core table, command sequencer and result register.
//
// One command word in, one result word out. The core table holds up to MAX_CPUS
// entries; each entry's affinity ID lives in a small RAM and its on/off state in
// a flag register. register, version, cpu_off, suspend, the system-wide off and
// reset, and features go from accept straight to the done state. cpu_on and
// affinity_info search the table from entry 0 with one 40-bit comparator that
// is reused for every entry; each entry examined passes a RAM read state, then a
// compare state, and the search stops at the first match or after the last entry
// in use. s_axis_tready is high only while the sequencer is idle; a finished
// result sits in the output register until taken, and the next word is accepted
// meanwhile. In the result word, value carries major<<16|minor for version, the
// core state (0 on, 1 off) for a successful affinity_info, and zero otherwise.
// Cores only ever move between off and on here, so the pending state is never
// reported. The entry address is checked (a zero entry address fails cpu_on) and
// the context word is ignored; neither is kept, since no command reads them back.
// No clearing pass is needed after reset; table entries at or above the core
// count are never read. Configuration writes are always taken and must only be
// issued while the block is idle.
module cpu_power_state_coordinator_unit #(
    parameter int MAX_CPUS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Command channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: affinity_id[39:0], core_index[47:40], entry_address[111:48],
    //        context_word[175:112], function_id[207:176]
    input  logic [cpsc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd[3:0]
    input  logic [cpsc_pkg::CMD_W-1:0]       s_axis_tuser,
    // Result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: status[2:0], value[33:3], zero pad[39:34]
    output logic [cpsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cpsc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cpsc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import cpsc_pkg::*;

    localparam int IDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNT_W = $clog2(MAX_CPUS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Control
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_valid;
    logic [MAJOR_W-1:0]   r_ver_major;
    logic [MINOR_W-1:0]   r_ver_minor;

    // Payload
    logic [IDX_W-1:0]     r_idx;
    logic [AFF_W-1:0]     r_aff;
    logic                 r_is_on_cmd;
    logic                 r_entry_nz;
    logic [MAX_CPUS-1:0]  r_pwr_on;
    t_status              r_res_status;
    logic [VALUE_W-1:0]   r_res_value;
    t_status              r_out_status;
    logic [VALUE_W-1:0]   r_out_value;

    // Input fields
    logic [CMD_W-1:0]     in_cmd;
    logic [AFF_W-1:0]     in_aff;
    logic [CIDX_W-1:0]    in_cidx;
    logic [ENTRY_W-1:0]   in_entry;
    logic [FN_W-1:0]      in_fn;

    assign in_cmd   = s_axis_tuser;
    assign in_aff   = s_axis_tdata[AFF_LSB +: AFF_W];
    assign in_cidx  = s_axis_tdata[CIDX_LSB +: CIDX_W];
    assign in_entry = s_axis_tdata[ENTRY_LSB +: ENTRY_W];
    assign in_fn    = s_axis_tdata[FN_LSB +: FN_W];

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Affinity RAM, written on register, read by the search
    logic             ram_we;
    logic [AFF_W-1:0] ram_rd;
    logic             table_full;

    assign table_full = (r_count >= CNT_W'(MAX_CPUS));
    assign ram_we     = accept && (in_cmd == CMD_REGISTER) && !table_full;

    cpsc_ram #(
        .WIDTH (AFF_W),
        .DEPTH (MAX_CPUS)
    ) u_aff_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (in_aff),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_rd)
    );

    // Version gates for the optional functions
    logic ver_ge_1_1, ver_ge_1_2;
    assign ver_ge_1_1 = (r_ver_major != MAJOR_W'(1)) ? (r_ver_major > MAJOR_W'(1))
                                                       : (r_ver_minor >= MINOR_W'(1));
    assign ver_ge_1_2 = (r_ver_major != MAJOR_W'(1)) ? (r_ver_major > MAJOR_W'(1))
                                                       : (r_ver_minor >= MINOR_W'(2));

    t_status feat_status;
    always_comb begin
        case (in_fn)
            FN_VERSION, FN_CPU_SUSPEND, FN_CPU_OFF, FN_CPU_ON, FN_AFFINITY_INFO,
            FN_SHUTDOWN, FN_SYSTEM_RESET, FN_FEATURES: begin
                feat_status = ST_SUCCESS;
            end
            FN_STAT_RESIDENCY, FN_STAT_COUNT, FN_SYSTEM_RESET2: begin
                feat_status = ver_ge_1_1 ? ST_SUCCESS : ST_NOT_SUPPORTED;
            end
            FN_MEM_PROTECT: begin
                feat_status = ver_ge_1_2 ? ST_SUCCESS : ST_NOT_SUPPORTED;
            end
            default: begin
                feat_status = ST_NOT_SUPPORTED;
            end
        endcase
    end

    // Dispatch on accept: immediate result, or start a table search
    logic               idx_ok;
    logic               cidx_on;
    t_status            d_status;
    logic [VALUE_W-1:0] d_value;
    logic               d_search;

    assign idx_ok  = (in_cidx < CIDX_W'(r_count));
    assign cidx_on = r_pwr_on[in_cidx[IDX_W-1:0]];

    always_comb begin
        d_status = ST_SUCCESS;
        d_value  = '0;
        d_search = 1'b0;
        case (in_cmd)
            CMD_REGISTER: begin
                if (table_full) begin
                    d_status = ST_TABLE_FULL;
                end
            end
            CMD_VERSION: begin
                d_value = {r_ver_major, r_ver_minor};
            end
            CMD_CPU_ON, CMD_AFFINITY: begin
                if (r_count == '0) begin
                    d_status = ST_INVALID_PARAMS;
                end else begin
                    d_search = 1'b1;
                end
            end
            CMD_CPU_OFF, CMD_SUSPEND: begin
                if (!idx_ok) begin
                    d_status = ST_INVALID_PARAMS;
                end else if (!cidx_on) begin
                    d_status = ST_DENIED;
                end
            end
            CMD_ALL_OFF, CMD_SYSTEM_RESET: begin
                d_status = ST_SUCCESS;
            end
            CMD_FEATURES: begin
                d_status = feat_status;
            end
            default: begin
                d_status = ST_NOT_SUPPORTED;
            end
        endcase
    end

    // Search step: shared comparator against the entry just read
    logic match, last;
    assign match = (ram_rd == r_aff);
    assign last  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = d_search ? S_READ : S_DONE;
                end
            end
            S_READ: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = (match || last) ? S_DONE : S_READ;
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    logic out_load;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_ver_major <= MAJOR_RESET;
            r_ver_minor <= MINOR_RESET;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VERSION_MAJOR: r_ver_major <= i_cfg_data[MAJOR_W-1:0];
                    CFG_VERSION_MINOR: r_ver_minor <= i_cfg_data[MINOR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers and core state flags
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_value  <= r_res_value;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_aff        <= in_aff;
                    r_is_on_cmd  <= (in_cmd == CMD_CPU_ON);
                    r_entry_nz   <= |in_entry;
                    r_res_status <= d_status;
                    r_res_value  <= d_value;
                    r_idx        <= '0;
                    if (ram_we) begin
                        r_pwr_on[r_count[IDX_W-1:0]] <= 1'b0;
                    end
                    if ((in_cmd == CMD_CPU_OFF) && idx_ok && cidx_on) begin
                        r_pwr_on[in_cidx[IDX_W-1:0]] <= 1'b0;
                    end
                    if ((in_cmd == CMD_ALL_OFF) || (in_cmd == CMD_SYSTEM_RESET)) begin
                        r_pwr_on <= '0;
                    end
                end
            end
            S_CMP: begin
                if (match) begin
                    if (r_is_on_cmd) begin
                        if (r_pwr_on[r_idx]) begin
                            r_res_status <= ST_ALREADY_ON;
                        end else if (!r_entry_nz) begin
                            r_res_status <= ST_INVALID_ADDRESS;
                        end else begin
                            r_res_status     <= ST_SUCCESS;
                            r_pwr_on[r_idx]  <= 1'b1;
                        end
                    end else begin
                        r_res_status <= ST_SUCCESS;
                        r_res_value  <= r_pwr_on[r_idx] ? PW_ON : PW_OFF;
                    end
                end else if (last) begin
                    r_res_status <= ST_INVALID_PARAMS;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), r_out_value, r_out_status};

endmodule

FILE: hdl/cpsc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the CPU power-state coordinator, bound to the top level.
module cpsc_port_props (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [cpsc_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    import cpsc_pkg::*;

    // Result register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    // One command at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("command accepted twice in a row");

    // A new result is only loaded while the command side is busy
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a command in flight");

    // Stalled result word holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind cpu_power_state_coordinator_unit cpsc_port_props u_cpsc_checker (.*);
